// ===== rtl/playfair_digraph_encrypt_top_defines.svh =====
// Assertion helpers shared by pfd_fifo and pfd_back.
// Both expect clk_i in the scope where they are used; PFD_ASSERT also expects rst_ni.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_TOP_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define PFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define PFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/pfd_pkg.sv =====
package pfd_pkg;

  localparam int unsigned LetterW   = 5;
  localparam int unsigned Side      = 5;
  localparam int unsigned Cells     = Side * Side;
  localparam int unsigned IdxW      = $clog2(Cells);
  localparam int unsigned RowW      = $clog2(Side);
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 45;
  localparam int unsigned PartAW    = 45;
  localparam int unsigned PartBW    = 40;
  localparam int unsigned PartCW    = 40;
  localparam int unsigned PartACells = PartAW / LetterW;
  localparam int unsigned PartBCells = PartBW / LetterW;
  localparam int unsigned PartCCells = PartCW / LetterW;
  localparam int unsigned TdataW    = 8;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [RowW-1:0]    coord_t;
  typedef letter_t            square_t [Cells];

  localparam letter_t LetterI     = letter_t'(8);
  localparam letter_t LetterJ     = letter_t'(9);
  localparam letter_t FillerReset = letter_t'(23);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SQUARE_A = 2'd0,
    CFG_SQUARE_B = 2'd1,
    CFG_SQUARE_C = 2'd2,
    CFG_FILLER   = 2'd3
  } cfg_reg_e;

  // One digraph queued between front and back.
  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    last;
  } digraph_t;

  // Queue write request: zero, one or two digraphs in one cycle.
  typedef struct packed {
    logic [1:0] count;
    digraph_t   d0;
    digraph_t   d1;
  } push_t;

  function automatic letter_t fold_letter(letter_t v);
    return (v == LetterJ) ? LetterI : v;
  endfunction

  function automatic coord_t row_of(idx_t p);
    coord_t r;
    r = '0;
    for (int k = 1; k < Side; k++) begin
      if (p >= idx_t'(k * Side)) r = coord_t'(k);
    end
    return r;
  endfunction

  function automatic idx_t pos_of(coord_t r, coord_t c);
    idx_t rr;
    idx_t cc;
    rr = idx_t'(r);
    cc = idx_t'(c);
    return idx_t'(rr * idx_t'(Side)) + cc;
  endfunction

  function automatic coord_t col_of(idx_t p);
    return coord_t'(p - pos_of(row_of(p), '0));
  endfunction

  function automatic coord_t step_mod(coord_t v);
    return (v == coord_t'(Side - 1)) ? '0 : coord_t'(v + coord_t'(1));
  endfunction

endpackage

// ===== rtl/playfair_digraph_encrypt_top.sv =====
// Playfair 5x5 digraph encryptor.
// Input stream: one plaintext letter per request; tdata[4:0] is the letter
// (0 is A, J is folded into I) and tlast marks the final letter of the text.
// Output stream: one cipher letter per request in tdata[4:0]; tlast is set on
// the final letter produced by one input request. An input yields zero, two
// or four output letters.
// Configuration: a write port loads the key square in three parts and the
// filler letter. Write it only while the block is idle.
// A front stage tracks the pending letter and queues digraphs in a four-entry
// queue; the back stage locates both letters in the square, applies the rules
// and emits the two cipher letters from one output register.
// Path: a completed digraph passes the queue, a held slot and the output register;
// its second cipher letter follows the first through the same output register.
// Throughput: one output letter per cycle while digraphs are queued and the
// receiver is ready, set by the back stage emitting both letters through one register.
// Input is stalled only when the queue has fewer than two free entries.
// Reset clears the pending letter, the queue and the output, sets the square
// to all zeros and the filler letter to X. A receiver stall holds the output
// letter stable; the queue keeps taking input until fewer than two entries
// are free.
module playfair_digraph_encrypt_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pfd_pkg::TdataW-1:0]     s_axis_tdata,   // [4:0] plain_letter, rest zero
  input  logic                           s_axis_tlast,   // end_of_text
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pfd_pkg::TdataW-1:0]     m_axis_tdata,   // [4:0] cipher_letter, rest zero
  output logic                           m_axis_tlast,   // last_of_run
  input  logic                           cfg_we_i,
  input  logic [pfd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [pfd_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  logic [pfd_pkg::PartAW-1:0] sq_a_q;
  logic [pfd_pkg::PartBW-1:0] sq_b_q;
  logic [pfd_pkg::PartCW-1:0] sq_c_q;
  pfd_pkg::letter_t           filler_q;
  pfd_pkg::square_t           square;

  pfd_pkg::push_t    push;
  logic              space_ok;
  logic              head_valid;
  pfd_pkg::digraph_t head;
  logic              pop;
  pfd_pkg::letter_t  out_letter;

  // Configuration registers, written by index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_a_q   <= '0;
      sq_b_q   <= '0;
      sq_c_q   <= '0;
      filler_q <= pfd_pkg::FillerReset;
    end else if (cfg_we_i) begin
      case (pfd_pkg::cfg_reg_e'(cfg_idx_i))
        pfd_pkg::CFG_SQUARE_A: sq_a_q   <= cfg_wdata_i[pfd_pkg::PartAW-1:0];
        pfd_pkg::CFG_SQUARE_B: sq_b_q   <= cfg_wdata_i[pfd_pkg::PartBW-1:0];
        pfd_pkg::CFG_SQUARE_C: sq_c_q   <= cfg_wdata_i[pfd_pkg::PartCW-1:0];
        pfd_pkg::CFG_FILLER:   filler_q <= cfg_wdata_i[pfd_pkg::LetterW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the three parts into the 25 cells in row-major order.
  always_comb begin
    for (int k = 0; k < pfd_pkg::PartACells; k++) begin
      square[k] = sq_a_q[k*pfd_pkg::LetterW +: pfd_pkg::LetterW];
    end
    for (int k = 0; k < pfd_pkg::PartBCells; k++) begin
      square[pfd_pkg::PartACells + k] = sq_b_q[k*pfd_pkg::LetterW +: pfd_pkg::LetterW];
    end
    for (int k = 0; k < pfd_pkg::PartCCells; k++) begin
      square[pfd_pkg::PartACells + pfd_pkg::PartBCells + k] =
        sq_c_q[k*pfd_pkg::LetterW +: pfd_pkg::LetterW];
    end
  end

  pfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_letter_i (s_axis_tdata[pfd_pkg::LetterW-1:0]),
    .in_last_i   (s_axis_tlast),
    .filler_i    (filler_q),
    .space_ok_i  (space_ok),
    .in_ready_o  (s_axis_tready),
    .push_o      (push)
  );

  pfd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .space_ok_o   (space_ok),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .square_i     (square),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_letter_o (out_letter),
    .out_last_o   (m_axis_tlast),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {{(pfd_pkg::TdataW - pfd_pkg::LetterW){1'b0}}, out_letter};

endmodule

// ===== rtl/pfd_front.sv =====
module pfd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  pfd_pkg::letter_t       in_letter_i,
  input  logic                   in_last_i,
  input  pfd_pkg::letter_t       filler_i,
  input  logic                   space_ok_i,
  output logic                   in_ready_o,
  output pfd_pkg::push_t         push_o
);

  logic             pend_v_q, pend_v_d;
  pfd_pkg::letter_t pend_q, pend_d;
  pfd_pkg::letter_t letter;
  pfd_pkg::letter_t fill;
  logic             take;

  assign in_ready_o = space_ok_i;
  assign take       = in_valid_i && space_ok_i;
  assign letter     = pfd_pkg::fold_letter(in_letter_i);
  assign fill       = pfd_pkg::fold_letter(filler_i);

  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    push_o   = '0;
    if (take) begin
      if (!pend_v_q) begin
        if (in_last_i) begin
          push_o.count = 2'd1;
          push_o.d0    = '{first: letter, second: fill, last: 1'b1};
        end else begin
          pend_v_d = 1'b1;
          pend_d   = letter;
        end
      end else if (pend_q != letter) begin
        push_o.count = 2'd1;
        push_o.d0    = '{first: pend_q, second: letter, last: 1'b1};
        pend_v_d     = 1'b0;
        pend_d       = '0;
      end else if (!in_last_i) begin
        // Doubled letter: pair with the filler, the new copy stays pending.
        push_o.count = 2'd1;
        push_o.d0    = '{first: pend_q, second: fill, last: 1'b1};
      end else begin
        // Doubled letter at the end of text: both copies get the filler.
        push_o.count = 2'd2;
        push_o.d0    = '{first: pend_q, second: fill, last: 1'b0};
        push_o.d1    = '{first: letter, second: fill, last: 1'b1};
        pend_v_d     = 1'b0;
        pend_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      pend_q   <= '0;
    end else begin
      pend_v_q <= pend_v_d;
      pend_q   <= pend_d;
    end
  end

endmodule

// ===== rtl/pfd_fifo.sv =====
`include "playfair_digraph_encrypt_top_defines.svh"

module pfd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfd_pkg::push_t     push_i,
  input  logic               pop_i,
  output logic               space_ok_o,
  output logic               head_valid_o,
  output pfd_pkg::digraph_t  head_o
);

  pfd_pkg::digraph_t                  mem_q [pfd_pkg::FifoDepth];
  logic [pfd_pkg::FifoPtrW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [pfd_pkg::FifoCntW-1:0]       cnt_q, cnt_d;

  assign space_ok_o   = cnt_q <= pfd_pkg::FifoCntW'(pfd_pkg::FifoDepth - 2);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rptr_q];
  assign wptr_nx      = wptr_q + pfd_pkg::FifoPtrW'(1);

  always_comb begin
    wptr_d = wptr_q + pfd_pkg::FifoPtrW'(push_i.count);
    rptr_d = pop_i ? rptr_q + pfd_pkg::FifoPtrW'(1) : rptr_q;
    cnt_d  = cnt_q + pfd_pkg::FifoCntW'(push_i.count)
             - pfd_pkg::FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.d0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr_nx] <= push_i.d1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  `PFD_ASSERT(a_fifo_bound, cnt_q <= pfd_pkg::FifoCntW'(pfd_pkg::FifoDepth), "queue overfilled")
  `PFD_ASSERT(a_fifo_no_overrun, (push_i.count != 2'd0) |-> (cnt_q + pfd_pkg::FifoCntW'(push_i.count) <= pfd_pkg::FifoCntW'(pfd_pkg::FifoDepth)), "push without room")
  `PFD_ASSERT(a_fifo_no_underrun, pop_i |-> head_valid_o, "pop from empty queue")

endmodule

// ===== rtl/pfd_back.sv =====
`include "playfair_digraph_encrypt_top_defines.svh"

module pfd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfd_pkg::square_t   square_i,
  input  logic               head_valid_i,
  input  pfd_pkg::digraph_t  head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output pfd_pkg::letter_t   out_letter_o,
  output logic               out_last_o,
  input  logic               out_ready_i
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'b01,
    PH_SECOND = 2'b10
  } phase_e;

  // Last matching cell in row-major order; a missing letter sits at cell 0.
  function automatic pfd_pkg::idx_t locate(pfd_pkg::square_t sq, pfd_pkg::letter_t l);
    pfd_pkg::idx_t where;
    where = '0;
    for (int k = 0; k < pfd_pkg::Cells; k++) begin
      if (sq[k] == l) where = pfd_pkg::idx_t'(k);
    end
    return where;
  endfunction

  pfd_pkg::idx_t    p, q, a, b;
  pfd_pkg::coord_t  r1, c1, r2, c2;

  logic             slot_v_q, slot_v_d;
  pfd_pkg::idx_t    slot_a_q, slot_b_q;
  logic             slot_last_q;
  phase_e           phase_q, phase_d;

  logic             out_v_q, out_v_d;
  pfd_pkg::letter_t out_l_q;
  logic             out_last_q;
  logic             out_load;
  logic             slot_done;

  // Locate both letters and apply the square rules on the queue head.
  always_comb begin
    p  = locate(square_i, head_i.first);
    q  = locate(square_i, head_i.second);
    r1 = pfd_pkg::row_of(p);
    c1 = pfd_pkg::col_of(p);
    r2 = pfd_pkg::row_of(q);
    c2 = pfd_pkg::col_of(q);
    if (r1 == r2) begin
      a = pfd_pkg::pos_of(r1, pfd_pkg::step_mod(c1));
      b = pfd_pkg::pos_of(r2, pfd_pkg::step_mod(c2));
    end else if (c1 == c2) begin
      a = pfd_pkg::pos_of(pfd_pkg::step_mod(r1), c1);
      b = pfd_pkg::pos_of(pfd_pkg::step_mod(r2), c2);
    end else begin
      a = pfd_pkg::pos_of(r1, c2);
      b = pfd_pkg::pos_of(r2, c1);
    end
  end

  assign out_load  = slot_v_q && (!out_v_q || out_ready_i);
  assign slot_done = out_load && (phase_q == PH_SECOND);
  assign pop_o     = head_valid_i && (!slot_v_q || slot_done);

  always_comb begin
    slot_v_d = slot_v_q;
    phase_d  = phase_q;
    out_v_d  = out_v_q;
    if (out_valid_o && out_ready_i) out_v_d = 1'b0;
    if (out_load) begin
      out_v_d = 1'b1;
      phase_d = (phase_q == PH_FIRST) ? PH_SECOND : PH_FIRST;
    end
    if (slot_done) slot_v_d = 1'b0;
    if (pop_o) begin
      slot_v_d = 1'b1;
      phase_d  = PH_FIRST;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      slot_a_q    <= a;
      slot_b_q    <= b;
      slot_last_q <= head_i.last;
    end
    if (out_load) begin
      if (phase_q == PH_FIRST) begin
        out_l_q    <= square_i[slot_a_q];
        out_last_q <= 1'b0;
      end else begin
        out_l_q    <= square_i[slot_b_q];
        out_last_q <= slot_last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_v_q <= 1'b0;
      phase_q  <= PH_FIRST;
      out_v_q  <= 1'b0;
    end else begin
      slot_v_q <= slot_v_d;
      phase_q  <= phase_d;
      out_v_q  <= out_v_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_letter_o = out_l_q;
  assign out_last_o   = out_last_q;

  `PFD_ASSERT(a_back_pop_fills, pop_o |=> slot_v_q && phase_q == PH_FIRST, "popped digraph not held")
  `PFD_ASSERT(a_back_slot_kept, (slot_v_q && !out_load) |=> slot_v_q, "digraph lost while stalled")
  `PFD_ASSERT(a_back_second_last, slot_done |=> out_last_q == $past(slot_last_q), "wrong last flag")

endmodule

// ===== tb/playfair_digraph_encrypt_top_tb.sv =====
`timescale 1ns / 1ps

module playfair_digraph_encrypt_top_tb;
  import pfd_pkg::*;

  localparam int TdW          = TdataW;
  localparam int CycleLimit   = 200000;
  // Settle margin for the queue, the held slot and the output register.
  localparam int SettleCycles = 10;

  typedef struct {
    letter_t letter;
    logic    eot;
  } plain_req_t;

  typedef struct {
    letter_t letter;
    logic    last;
  } cipher_res_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TdW-1:0]       s_axis_tdata  = '0;   // [4:0] plain_letter, rest zero
  logic                 s_axis_tlast  = 1'b0; // end_of_text
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TdW-1:0]       m_axis_tdata;         // [4:0] cipher_letter, rest zero
  logic                 m_axis_tlast;         // last_of_run
  logic                 cfg_we_i      = 1'b0;
  cfg_reg_e             cfg_idx_i     = CFG_SQUARE_A;
  logic [CfgDataW-1:0]  cfg_wdata_i   = '0;

  playfair_digraph_encrypt_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Plaintext letters waiting to be sent and cipher letters still owed by the block.
  plain_req_t  plain_q[$];
  cipher_res_t cipher_q[$];

  // Shadow copy of the key square, the filler and the pending letter.
  logic [PartAW-1:0] key_a       = '0;
  logic [PartBW-1:0] key_b       = '0;
  logic [PartCW-1:0] key_c       = '0;
  letter_t           fill_reg    = FillerReset;
  bit                held_valid  = 1'b0;
  letter_t           held_letter = '0;
  // Cells of the square last loaded, used to pick letters that sit at known places.
  letter_t           key_cells [Cells];

  int  err_count = 0;
  int  cycle_cnt = 0;
  int  feed_gap  = 0;
  int  drain_gap = 0;
  bit  feed_calm = 1'b0;
  bit  drain_calm = 1'b0;

  function automatic letter_t fold(letter_t v);
    return (v == LetterJ) ? LetterI : v;
  endfunction

  function automatic letter_t cell_of(int k);
    if (k < PartACells) return key_a[LetterW*k +: LetterW];
    if (k < PartACells + PartBCells) return key_b[LetterW*(k-PartACells) +: LetterW];
    return key_c[LetterW*(k-PartACells-PartBCells) +: LetterW];
  endfunction

  // A letter found more than once sits at its last place; one that is missing sits at 0.
  function automatic int where_is(letter_t v);
    int pos;
    pos = 0;
    for (int k = 0; k < Cells; k++) begin
      if (cell_of(k) == v) pos = k;
    end
    return pos;
  endfunction

  task automatic cipher_pair(letter_t first, letter_t second, logic last_flag);
    int p, q, r1, c1, r2, c2, a, b;
    p  = where_is(first);
    q  = where_is(second);
    r1 = p / Side;
    c1 = p % Side;
    r2 = q / Side;
    c2 = q % Side;
    if (r1 == r2) begin
      a = r1 * Side + (c1 + 1) % Side;
      b = r2 * Side + (c2 + 1) % Side;
    end else if (c1 == c2) begin
      a = ((r1 + 1) % Side) * Side + c1;
      b = ((r2 + 1) % Side) * Side + c2;
    end else begin
      a = r1 * Side + c2;
      b = r2 * Side + c1;
    end
    cipher_q.push_back('{cell_of(a), 1'b0});
    cipher_q.push_back('{cell_of(b), last_flag});
  endtask

  // Digraph formation for one accepted plaintext letter.
  task automatic predict_plain(plain_req_t req);
    letter_t ltr, fl;
    ltr = fold(req.letter);
    fl  = fold(fill_reg);
    if (!held_valid) begin
      if (req.eot) begin
        cipher_pair(ltr, fl, 1'b1);
      end else begin
        held_valid  = 1'b1;
        held_letter = ltr;
      end
    end else if (held_letter != ltr) begin
      cipher_pair(held_letter, ltr, 1'b1);
      held_valid  = 1'b0;
      held_letter = '0;
    end else if (req.eot) begin
      // A doubled final letter flushes two filler digraphs.
      cipher_pair(held_letter, fl, 1'b0);
      cipher_pair(ltr, fl, 1'b1);
      held_valid  = 1'b0;
      held_letter = '0;
    end else begin
      cipher_pair(held_letter, fl, 1'b1);
    end
  endtask

  // Sender: presents the oldest pending letter and waits a random gap after each request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_plain(plain_q.pop_front());
        if ($urandom_range(0, 15) == 0) feed_calm = !feed_calm;
        feed_gap = feed_calm ? 0 : $urandom_range(0, 4);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (feed_gap != 0) begin
          feed_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (plain_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= TdW'(plain_q[0].letter);
          s_axis_tlast  <= plain_q[0].eot;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each cipher letter against the oldest owed one, then stalls at random.
  always @(posedge clk_i) begin
    cipher_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected cipher letter %0d last %0b", m_axis_tdata, m_axis_tlast);
        end else begin
          want = cipher_q.pop_front();
          if (m_axis_tdata !== TdW'(want.letter) || m_axis_tlast !== want.last) begin
            err_count++;
            if (err_count <= 10)
              $display("cipher mismatch: expected letter %0d last %0b, got letter %0d last %0b",
                       want.letter, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
        if ($urandom_range(0, 15) == 0) drain_calm = !drain_calm;
        drain_gap = drain_calm ? 0 : $urandom_range(0, 4);
      end
      if (drain_gap != 0) begin
        drain_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[playfair_digraph_encrypt_top] ERROR");
      $finish;
    end
  end

  function automatic logic [CfgDataW-1:0] rand_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[CfgDataW-1:0];
  endfunction

  // Blocks until the block has taken every letter and returned every cipher letter.
  task automatic wait_idle();
    while (plain_q.size() != 0 || s_axis_tvalid || cipher_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The shadow copy is updated at once; no request is in flight while this runs.
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_SQUARE_A: key_a = val[PartAW-1:0];
      CFG_SQUARE_B: key_b = val[PartBW-1:0];
      CFG_SQUARE_C: key_c = val[PartCW-1:0];
      CFG_FILLER:   fill_reg = val[LetterW-1:0];
      default: ;
    endcase
  endtask

  // Loads key_cells into the square and sets the filler; unused upper bits carry noise.
  task automatic load_setting(letter_t filler);
    logic [CfgDataW-1:0] wa, wb, wc, wf;
    wait_idle();
    wa = '0;
    wb = rand_word();
    wc = rand_word();
    wf = rand_word();
    for (int k = 0; k < PartACells; k++) wa[LetterW*k +: LetterW] = key_cells[k];
    for (int k = 0; k < PartBCells; k++)
      wb[LetterW*k +: LetterW] = key_cells[PartACells + k];
    for (int k = 0; k < PartCCells; k++)
      wc[LetterW*k +: LetterW] = key_cells[PartACells + PartBCells + k];
    wf[LetterW-1:0] = filler;
    write_reg(CFG_SQUARE_A, wa);
    write_reg(CFG_SQUARE_B, wb);
    write_reg(CFG_SQUARE_C, wc);
    write_reg(CFG_FILLER, wf);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Writes the same word to all four registers, for the all-zero and all-one extremes.
  task automatic load_flat(logic [CfgDataW-1:0] val);
    wait_idle();
    for (int k = 0; k < Cells; k++) key_cells[k] = val[LetterW-1:0];
    write_reg(CFG_SQUARE_A, val);
    write_reg(CFG_SQUARE_B, val);
    write_reg(CFG_SQUARE_C, val);
    write_reg(CFG_FILLER, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A proper key square: the 25 letters without J in random order.
  task automatic make_perm();
    int n, j;
    letter_t tmp;
    n = 0;
    for (int v = 0; v < 26; v++) begin
      if (letter_t'(v) != LetterJ) begin
        key_cells[n] = letter_t'(v);
        n++;
      end
    end
    for (int k = Cells - 1; k > 0; k--) begin
      j            = $urandom_range(0, k);
      tmp          = key_cells[k];
      key_cells[k] = key_cells[j];
      key_cells[j] = tmp;
    end
  endtask

  // A malformed square with repeats, holes and entries above Z.
  task automatic make_raw();
    for (int k = 0; k < Cells; k++) key_cells[k] = letter_t'($urandom_range(0, 31));
  endtask

  task automatic add(letter_t l, logic e);
    plain_q.push_back('{l, e});
  endtask

  // Mostly letters of the alphabet, with doubled letters, J, square picks and
  // out-of-range codes mixed in; about one letter in six ends a message.
  task automatic add_random(int count);
    letter_t l, prev;
    int r;
    prev = '0;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 11);
      if (r < 2 && i > 0) l = prev;
      else if (r == 2) l = letter_t'($urandom_range(0, 31));
      else if (r == 3) l = LetterJ;
      else if (r < 6) l = key_cells[$urandom_range(0, Cells - 1)];
      else l = letter_t'($urandom_range(0, 25));
      add(l, ($urandom_range(0, 5) == 0));
      prev = l;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: an all-zero square and X as the filler.
    add(5, 1'b0);
    add(7, 1'b1);
    add(3, 1'b1);

    // Directed letters against a proper square, starting with nothing pending.
    make_perm();
    load_setting(FillerReset);
    add(key_cells[0], 1'b0);  add(key_cells[1], 1'b0);    // same row
    add(key_cells[0], 1'b0);  add(key_cells[5], 1'b0);    // same column
    add(key_cells[6], 1'b0);  add(key_cells[18], 1'b0);   // rectangle
    add(key_cells[24], 1'b0); add(key_cells[20], 1'b0);   // row wraps around
    add(key_cells[24], 1'b0); add(key_cells[4], 1'b0);    // column wraps around
    add(LetterJ, 1'b0); add(LetterI, 1'b0);               // J folds into a doubled I
    add(key_cells[2], 1'b0);
    add(4, 1'b0); add(4, 1'b1);                           // doubled final letter
    add(12, 1'b1);                                        // lone final letter
    add(31, 1'b0); add(26, 1'b0);                         // codes missing from the square
    add(FillerReset, 1'b0); add(FillerReset, 1'b1);       // letter equal to the filler
    add(0, 1'b0); add(25, 1'b0);
    add_random(25);

    // J as the filler, which folds into I.
    make_perm();
    load_setting(LetterJ);
    add(LetterI, 1'b0); add(LetterI, 1'b0); add(LetterI, 1'b1);
    add_random(30);

    make_raw();
    load_setting(letter_t'($urandom_range(0, 31)));
    add_random(30);

    // Everything written as ones: only code 31 is found, at the last place.
    load_flat('1);
    add(31, 1'b0); add(31, 1'b1); add(0, 1'b1);
    add_random(15);

    load_flat('0);
    add(0, 1'b0); add(0, 1'b1);
    add_random(15);

    make_perm();
    load_setting(letter_t'($urandom_range(0, 25)));
    add_random(30);

    make_raw();
    load_setting(letter_t'($urandom_range(0, 31)));
    add_random(10);

    wait_idle();
    if (err_count == 0) begin
      $display("[playfair_digraph_encrypt_top] OK");
    end else begin
      $display("[playfair_digraph_encrypt_top] ERROR");
    end
    $finish;
  end

endmodule
